// File: sv/mbf_pkg.sv
// Shared types, constants and the micro-op program of the Maxwell-Bloch step engine.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mbf_pkg;

    // Parameter defaults
    localparam int GRID_MAX_DEF   = 1024;
    localparam int REGION_MAX_DEF = 8;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int PC_PASSES_DEF  = 4;

    // Coefficient slots of one region
    localparam int COEF_COUNT = 11;
    localparam int C_D12      = 0;
    localparam int C_DT       = 1;
    localparam int C_TAU1     = 2;
    localparam int C_W12      = 3;
    localparam int C_G12      = 4;
    localparam int C_CP       = 5;
    localparam int C_CE       = 6;
    localparam int C_DXINV    = 7;
    localparam int C_CH       = 8;
    localparam int C_LAST     = 9;
    localparam int C_UPPER    = 10;

    // Region index storage width (covers up to 16 regions)
    localparam int REGION_W = 4;

    // Item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_INIT = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    // Configuration register indexes
    localparam logic CFG_GRID_POINTS = 1'b0;
    localparam logic CFG_PROBE_INDEX = 1'b1;

    // Micro-program layout
    localparam int UPC_W = 6;
    localparam logic [UPC_W-1:0] PASS_LAST = 6'd37;
    localparam logic [UPC_W-1:0] H_FIRST   = 6'd38;
    localparam logic [UPC_W-1:0] H_LAST    = 6'd40;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_AVG
    } t_alu_op;

    // Operand and destination codes of the working registers
    typedef enum logic [5:0] {
        O_ZERO, O_LO, O_UP, O_CRS, O_CIS, O_EFS, O_HFS, O_HN,
        O_LE, O_UE, O_CRE, O_CIE, O_EE,
        O_R11, O_R22, O_RR, O_RI, O_OM, O_T, O_TR, O_DRV, O_T0, O_T1,
        O_D12, O_DT, O_TAU1, O_W12, O_G12, O_CP, O_CE, O_DXI, O_CH, O_EPV
    } t_opnd;

    typedef struct packed {
        t_alu_op op;
        t_opnd   dst;
        t_opnd   a;
        t_opnd   b;
    } t_uop;

    // One cell of the grid
    typedef struct packed {
        logic signed [31:0]  lo;
        logic signed [31:0]  up;
        logic signed [31:0]  cr;
        logic signed [31:0]  ci;
        logic signed [31:0]  ef;
        logic signed [31:0]  hf;
        logic [REGION_W-1:0] rg;
    } t_cell;

    // Field write enables of the grid store
    typedef struct packed {
        logic pop;
        logic ef;
        logic hf;
        logic rg;
    } t_cell_we;

    function automatic t_uop mk(t_alu_op op, t_opnd d, t_opnd a, t_opnd b);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    // Predictor-corrector pass (0..37), then the H update (38..40)
    function automatic t_uop uop_rom(logic [UPC_W-1:0] idx);
        t_uop u;
        u = mk(OP_ADD, O_T0, O_ZERO, O_ZERO);
        case (idx)
            6'd0:  u = mk(OP_AVG, O_R11, O_LO,   O_LE);
            6'd1:  u = mk(OP_AVG, O_R22, O_UP,   O_UE);
            6'd2:  u = mk(OP_AVG, O_RR,  O_CRS,  O_CRE);
            6'd3:  u = mk(OP_AVG, O_RI,  O_CIS,  O_CIE);
            6'd4:  u = mk(OP_AVG, O_T0,  O_EFS,  O_EE);
            6'd5:  u = mk(OP_MUL, O_OM,  O_D12,  O_T0);
            6'd6:  u = mk(OP_MUL, O_T0,  O_OM,   O_RI);
            6'd7:  u = mk(OP_ADD, O_T,   O_T0,   O_T0);
            6'd8:  u = mk(OP_MUL, O_T0,  O_W12,  O_RI);
            6'd9:  u = mk(OP_MUL, O_T1,  O_G12,  O_RR);
            6'd10: u = mk(OP_SUB, O_DRV, O_T0,   O_T1);
            6'd11: u = mk(OP_SUB, O_T0,  O_ZERO, O_T);
            6'd12: u = mk(OP_MUL, O_TR,  O_TAU1, O_R11);
            6'd13: u = mk(OP_SUB, O_T0,  O_T0,   O_TR);
            6'd14: u = mk(OP_MUL, O_T0,  O_DT,   O_T0);
            6'd15: u = mk(OP_ADD, O_LE,  O_LO,   O_T0);
            6'd16: u = mk(OP_MUL, O_T0,  O_W12,  O_RR);
            6'd17: u = mk(OP_SUB, O_T0,  O_ZERO, O_T0);
            6'd18: u = mk(OP_SUB, O_T1,  O_R11,  O_R22);
            6'd19: u = mk(OP_MUL, O_T1,  O_OM,   O_T1);
            6'd20: u = mk(OP_ADD, O_T0,  O_T0,   O_T1);
            6'd21: u = mk(OP_MUL, O_T1,  O_G12,  O_RI);
            6'd22: u = mk(OP_SUB, O_T0,  O_T0,   O_T1);
            6'd23: u = mk(OP_MUL, O_T0,  O_DT,   O_T0);
            6'd24: u = mk(OP_ADD, O_CIE, O_CIS,  O_T0);
            6'd25: u = mk(OP_MUL, O_T0,  O_DT,   O_DRV);
            6'd26: u = mk(OP_ADD, O_CRE, O_CRS,  O_T0);
            6'd27: u = mk(OP_ADD, O_T0,  O_T,    O_TR);
            6'd28: u = mk(OP_MUL, O_T0,  O_DT,   O_T0);
            6'd29: u = mk(OP_ADD, O_UE,  O_UP,   O_T0);
            6'd30: u = mk(OP_MUL, O_T0,  O_CP,   O_D12);
            6'd31: u = mk(OP_MUL, O_T0,  O_T0,   O_DRV);
            6'd32: u = mk(OP_SUB, O_T0,  O_ZERO, O_T0);
            6'd33: u = mk(OP_SUB, O_T1,  O_HN,   O_HFS);
            6'd34: u = mk(OP_MUL, O_T1,  O_T1,   O_DXI);
            6'd35: u = mk(OP_ADD, O_T0,  O_T0,   O_T1);
            6'd36: u = mk(OP_MUL, O_T0,  O_CE,   O_T0);
            6'd37: u = mk(OP_ADD, O_EE,  O_EFS,  O_T0);
            6'd38: u = mk(OP_SUB, O_T0,  O_EFS,  O_EPV);
            6'd39: u = mk(OP_MUL, O_T0,  O_CH,   O_T0);
            6'd40: u = mk(OP_ADD, O_T0,  O_HFS,  O_T0);
            default: u = mk(OP_ADD, O_T0, O_ZERO, O_ZERO);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: sv/mbf_in_if.sv
// Input item channel: valid/ready handshake with the item fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mbf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [2:0]         region_sel;
    logic [3:0]         coef_sel;
    logic signed [31:0] coef_value;
    logic signed [31:0] source_value;

    modport source (output valid, mode, region_sel, coef_sel, coef_value, source_value,
                    input ready);
    modport sink (input valid, mode, region_sel, coef_sel, coef_value, source_value,
                  output ready);
endinterface

`default_nettype wire

// File: sv/mbf_out_if.sv
// Result item channel: valid/ready handshake with the probe cell values.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mbf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] probe_e;
    logic signed [31:0] probe_h;
    logic signed [31:0] probe_lower_pop;
    logic signed [31:0] probe_upper_pop;
    logic signed [31:0] probe_coh_real;
    logic signed [31:0] probe_coh_imag;
    logic               saturated;

    modport source (output valid, probe_e, probe_h, probe_lower_pop, probe_upper_pop,
                    probe_coh_real, probe_coh_imag, saturated, input ready);
    modport sink (input valid, probe_e, probe_h, probe_lower_pop, probe_upper_pop,
                  probe_coh_real, probe_coh_imag, saturated, output ready);
endinterface

`default_nettype wire

// File: sv/mbf_alu.sv
// Saturating fixed-point unit: add, subtract, rounded multiply, average.
// Depends on mbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbf_alu #(
    parameter int FRAC_BITS = mbf_pkg::FRAC_BITS_DEF
) (
    input  mbf_pkg::t_alu_op    i_op,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic signed [31:0]  o_y,
    output logic                o_sat
);
    localparam int PW = 66;
    localparam logic signed [PW-1:0] MAXV = PW'(32'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] MINV = PW'(32'sh8000_0000);
    localparam logic signed [PW-1:0] RND  = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [63:0]   w_prod;
    logic signed [PW-1:0] w_wide;

    // full-width result, then clip to 32 bits
    always_comb begin
        w_prod = i_a * i_b;
        case (i_op)
            mbf_pkg::OP_ADD: w_wide = PW'(i_a) + PW'(i_b);
            mbf_pkg::OP_SUB: w_wide = PW'(i_a) - PW'(i_b);
            mbf_pkg::OP_MUL: w_wide = (PW'(w_prod) + RND) >>> FRAC_BITS;
            default:         w_wide = (PW'(i_a) + PW'(i_b) + PW'(1)) >>> 1;
        endcase
        o_sat = (w_wide > MAXV) || (w_wide < MINV);
        if (w_wide > MAXV) begin
            o_y = 32'sh7FFF_FFFF;
        end else if (w_wide < MINV) begin
            o_y = 32'sh8000_0000;
        end else begin
            o_y = w_wide[31:0];
        end
    end
endmodule

`default_nettype wire

// File: sv/mbf_coef_store.sv
// Region coefficient table: one write port, one registered read port.
// Entries read as zero until written. Depends on mbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbf_coef_store #(
    parameter int REGION_MAX = mbf_pkg::REGION_MAX_DEF,
    localparam int DEPTH = REGION_MAX * mbf_pkg::COEF_COUNT,
    localparam int CA_W = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [CA_W-1:0]    i_wr_addr,
    input  logic signed [31:0] i_wd,
    input  logic [CA_W-1:0]    i_rd_addr,
    output logic signed [31:0] o_rd
);
    logic signed [31:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0]   r_valid;
    logic signed [31:0] r_rd;

    // track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wd;
        end
        r_rd <= r_valid[i_rd_addr] ? mem[i_rd_addr] : 32'sd0;
    end

    assign o_rd = r_rd;
endmodule

`default_nettype wire

// File: sv/mbf_cell_store.sv
// Grid cell memories: populations, coherence, E, H and region of every cell.
// One read address with registered data, one write address. Depends on mbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbf_cell_store #(
    parameter int GRID_MAX = mbf_pkg::GRID_MAX_DEF,
    localparam int IDX_W = $clog2(GRID_MAX)
) (
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output mbf_pkg::t_cell     o_rd,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  mbf_pkg::t_cell_we  i_we,
    input  mbf_pkg::t_cell     i_wd
);
    logic signed [31:0]           lo_mem [0:GRID_MAX-1];
    logic signed [31:0]           up_mem [0:GRID_MAX-1];
    logic signed [31:0]           cr_mem [0:GRID_MAX-1];
    logic signed [31:0]           ci_mem [0:GRID_MAX-1];
    logic signed [31:0]           ef_mem [0:GRID_MAX-1];
    logic signed [31:0]           hf_mem [0:GRID_MAX-1];
    logic [mbf_pkg::REGION_W-1:0] rg_mem [0:GRID_MAX-1];
    mbf_pkg::t_cell               r_rd;

    // write selected fields
    always_ff @(posedge i_clk) begin
        if (i_we.pop) begin
            lo_mem[i_wr_addr] <= i_wd.lo;
            up_mem[i_wr_addr] <= i_wd.up;
            cr_mem[i_wr_addr] <= i_wd.cr;
            ci_mem[i_wr_addr] <= i_wd.ci;
        end
        if (i_we.ef) begin
            ef_mem[i_wr_addr] <= i_wd.ef;
        end
        if (i_we.hf) begin
            hf_mem[i_wr_addr] <= i_wd.hf;
        end
        if (i_we.rg) begin
            rg_mem[i_wr_addr] <= i_wd.rg;
        end
    end

    // registered read of the whole cell
    always_ff @(posedge i_clk) begin
        r_rd.lo <= lo_mem[i_rd_addr];
        r_rd.up <= up_mem[i_rd_addr];
        r_rd.cr <= cr_mem[i_rd_addr];
        r_rd.ci <= ci_mem[i_rd_addr];
        r_rd.ef <= ef_mem[i_rd_addr];
        r_rd.hf <= hf_mem[i_rd_addr];
        r_rd.rg <= rg_mem[i_rd_addr];
    end

    assign o_rd = r_rd;
endmodule

`default_nettype wire

// File: sv/maxwell_bloch_fdtd_step.sv
// Maxwell-Bloch FDTD step engine. A grid init reads the region bounds and upper inits,
// then writes all GRID_MAX cells. A time step uses one shared saturating ALU running one
// micro-op per cycle against the cell memories. One item at a time; the result
// register frees the input while a result waits. Synchronous active-low reset clears
// control and the coefficient table; the grid memories hold garbage until initialised.
`timescale 1ns / 1ps
`default_nettype none

module maxwell_bloch_fdtd_step #(
    parameter int GRID_MAX   = mbf_pkg::GRID_MAX_DEF,
    parameter int REGION_MAX = mbf_pkg::REGION_MAX_DEF,
    parameter int FRAC_BITS  = mbf_pkg::FRAC_BITS_DEF,
    parameter int PC_PASSES  = mbf_pkg::PC_PASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    mbf_in_if.sink      i_item,
    mbf_out_if.source   o_result
);
    localparam int IDX_W = $clog2(GRID_MAX);
    localparam int CNT_W = $clog2(GRID_MAX + 1);
    localparam int CA_W  = $clog2(REGION_MAX * mbf_pkg::COEF_COUNT);
    localparam int K_W   = ($clog2(2 * REGION_MAX + 1) > 4) ? $clog2(2 * REGION_MAX + 1) : 4;
    localparam int PS_W  = (PC_PASSES > 1) ? $clog2(PC_PASSES) : 1;
    localparam int RW    = mbf_pkg::REGION_W;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ILOAD = 15'b000000000000010,
        S_IFILL = 15'b000000000000100,
        S_CRD   = 15'b000000000001000,
        S_HRD   = 15'b000000000010000,
        S_CLD   = 15'b000000000100000,
        S_CALC  = 15'b000000001000000,
        S_CWR   = 15'b000000010000000,
        S_ERD   = 15'b000000100000000,
        S_ELD   = 15'b000001000000000,
        S_ECH   = 15'b000010000000000,
        S_HCALC = 15'b000100000000000,
        S_HWR   = 15'b001000000000000,
        S_PRD   = 15'b010000000000000,
        S_PLD   = 15'b100000000000000
    } t_state;

    // working registers of one cell
    typedef struct packed {
        logic signed [31:0] lo, up, crs, cis, efs, hfs, hn;
        logic signed [31:0] le, ue, cre, cie, ee;
        logic signed [31:0] r11, r22, rr, ri, om, t, tr, drv, t0, t1, epv;
    } t_wk;

    t_state                   r_state;
    logic [10:0]              r_grid_pts;
    logic [9:0]               r_probe;
    logic [CNT_W-1:0]         r_cell;
    logic [CNT_W-1:0]         r_n;
    logic [K_W-1:0]           r_k;
    logic [PS_W-1:0]          r_pass;
    logic [mbf_pkg::UPC_W-1:0] r_upc;
    logic [RW-1:0]            r_region;
    logic                     r_sat;
    logic signed [31:0]       r_src;
    t_wk                      r_wk;
    logic signed [31:0]       r_cf [0:8];
    logic signed [31:0]       r_last [0:REGION_MAX-1];
    logic signed [31:0]       r_upinit [0:REGION_MAX-1];
    logic                     r_ov;
    logic signed [31:0]       r_o_e, r_o_h, r_o_lo, r_o_up, r_o_cr, r_o_ci;
    logic                     r_o_sat;

    logic                     w_acc;
    logic                     w_cw_we;
    logic [CA_W-1:0]          w_cw_addr;
    logic [CA_W-1:0]          w_cr_addr;
    logic signed [31:0]       w_coef;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [IDX_W-1:0]         w_probe_addr;
    mbf_pkg::t_cell           w_rd;
    mbf_pkg::t_cell           w_wd;
    mbf_pkg::t_cell_we        w_we;
    logic [CNT_W-1:0]         w_n;
    logic [RW-1:0]            w_init_rg;
    logic signed [31:0]       w_upper;
    mbf_pkg::t_uop            w_uop;
    logic signed [31:0]       w_a, w_b, w_y;
    logic                     w_sat;

    function automatic logic [CA_W-1:0] caddr(int r, int s);
        return CA_W'(r * mbf_pkg::COEF_COUNT + s);
    endfunction

    function automatic logic signed [31:0] pick(mbf_pkg::t_opnd c);
        logic signed [31:0] v;
        case (c)
            mbf_pkg::O_LO:   v = r_wk.lo;
            mbf_pkg::O_UP:   v = r_wk.up;
            mbf_pkg::O_CRS:  v = r_wk.crs;
            mbf_pkg::O_CIS:  v = r_wk.cis;
            mbf_pkg::O_EFS:  v = r_wk.efs;
            mbf_pkg::O_HFS:  v = r_wk.hfs;
            mbf_pkg::O_HN:   v = r_wk.hn;
            mbf_pkg::O_LE:   v = r_wk.le;
            mbf_pkg::O_UE:   v = r_wk.ue;
            mbf_pkg::O_CRE:  v = r_wk.cre;
            mbf_pkg::O_CIE:  v = r_wk.cie;
            mbf_pkg::O_EE:   v = r_wk.ee;
            mbf_pkg::O_R11:  v = r_wk.r11;
            mbf_pkg::O_R22:  v = r_wk.r22;
            mbf_pkg::O_RR:   v = r_wk.rr;
            mbf_pkg::O_RI:   v = r_wk.ri;
            mbf_pkg::O_OM:   v = r_wk.om;
            mbf_pkg::O_T:    v = r_wk.t;
            mbf_pkg::O_TR:   v = r_wk.tr;
            mbf_pkg::O_DRV:  v = r_wk.drv;
            mbf_pkg::O_T0:   v = r_wk.t0;
            mbf_pkg::O_T1:   v = r_wk.t1;
            mbf_pkg::O_D12:  v = r_cf[mbf_pkg::C_D12];
            mbf_pkg::O_DT:   v = r_cf[mbf_pkg::C_DT];
            mbf_pkg::O_TAU1: v = r_cf[mbf_pkg::C_TAU1];
            mbf_pkg::O_W12:  v = r_cf[mbf_pkg::C_W12];
            mbf_pkg::O_G12:  v = r_cf[mbf_pkg::C_G12];
            mbf_pkg::O_CP:   v = r_cf[mbf_pkg::C_CP];
            mbf_pkg::O_CE:   v = r_cf[mbf_pkg::C_CE];
            mbf_pkg::O_DXI:  v = r_cf[mbf_pkg::C_DXINV];
            mbf_pkg::O_CH:   v = r_cf[mbf_pkg::C_CH];
            mbf_pkg::O_EPV:  v = r_wk.epv;
            default:         v = 32'sd0;
        endcase
        return v;
    endfunction

    assign i_item.ready = (r_state == S_IDLE);
    assign w_acc        = i_item.valid && (r_state == S_IDLE);

    // coefficient writes from load items with a valid selector
    assign w_cw_we   = w_acc && (i_item.mode == mbf_pkg::MODE_LOAD)
                       && (32'(i_item.region_sel) < 32'(REGION_MAX))
                       && (32'(i_item.coef_sel) < 32'(mbf_pkg::COEF_COUNT));
    assign w_cw_addr = caddr(int'(i_item.region_sel), int'(i_item.coef_sel));

    // clamp grid size and probe cell
    always_comb begin
        if (32'(r_grid_pts) > 32'(GRID_MAX)) begin
            w_n = CNT_W'(GRID_MAX);
        end else if (r_grid_pts < 11'd2) begin
            w_n = CNT_W'(2);
        end else begin
            w_n = CNT_W'(r_grid_pts);
        end
        w_probe_addr = (32'(r_probe) >= 32'(GRID_MAX)) ? IDX_W'(GRID_MAX - 1)
                                                       : IDX_W'(r_probe);
    end

    // region of the cell being initialised: first region whose last index covers it
    always_comb begin
        w_init_rg = '0;
        w_upper   = 32'sd0;
        for (int j = REGION_MAX - 1; j >= 0; j--) begin
            if ($signed({1'b0, r_cell}) <= r_last[j]) begin
                w_init_rg = RW'(j);
            end
        end
        for (int j = 0; j < REGION_MAX; j++) begin
            if (w_init_rg == RW'(j)) begin
                w_upper = r_upinit[j];
            end
        end
    end

    // memory addresses and write-back per state
    always_comb begin
        w_cr_addr = '0;
        w_rd_addr = r_cell[IDX_W-1:0];
        w_wd      = '0;
        w_we      = '0;
        unique case (r_state)
            S_ILOAD: begin
                if (int'(r_k) < REGION_MAX) begin
                    w_cr_addr = caddr(int'(r_k), mbf_pkg::C_LAST);
                end else if (int'(r_k) < 2 * REGION_MAX) begin
                    w_cr_addr = caddr(int'(r_k) - REGION_MAX, mbf_pkg::C_UPPER);
                end
            end
            S_IFILL: begin
                w_wd.up = w_upper;
                w_wd.rg = w_init_rg;
                w_we    = '{pop: 1'b1, ef: 1'b1, hf: 1'b1, rg: 1'b1};
            end
            S_HRD: w_rd_addr = IDX_W'(r_cell + 1'b1);
            S_CLD: w_cr_addr = caddr(int'(r_region), int'(r_k));
            S_CWR: begin
                w_wd.lo = r_wk.le;
                w_wd.up = r_wk.ue;
                w_wd.cr = r_wk.cre;
                w_wd.ci = r_wk.cie;
                w_wd.ef = r_wk.ee;
                w_we    = '{pop: 1'b1, ef: 1'b1, hf: 1'b0, rg: 1'b0};
            end
            S_ELD: w_cr_addr = caddr(int'(w_rd.rg), mbf_pkg::C_CH);
            S_HWR: begin
                w_wd.hf = (r_cell == '0) ? 32'sd0 : r_wk.t0;
                w_we    = '{pop: 1'b0, ef: 1'b0, hf: 1'b1, rg: 1'b0};
            end
            S_PRD, S_PLD: w_rd_addr = w_probe_addr;
            default: ;
        endcase
    end

    // micro-op operands
    always_comb begin
        w_uop = mbf_pkg::uop_rom(r_upc);
        w_a   = pick(w_uop.a);
        w_b   = pick(w_uop.b);
    end

    mbf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_op  (w_uop.op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_y   (w_y),
        .o_sat (w_sat)
    );

    mbf_coef_store #(.REGION_MAX(REGION_MAX)) u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_cw_we),
        .i_wr_addr (w_cw_addr),
        .i_wd      (i_item.coef_value),
        .i_rd_addr (w_cr_addr),
        .o_rd      (w_coef)
    );

    mbf_cell_store #(.GRID_MAX(GRID_MAX)) u_cells (
        .i_clk     (i_clk),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd),
        .i_wr_addr (r_cell[IDX_W-1:0]),
        .i_we      (w_we),
        .i_wd      (w_wd)
    );

    // sequencer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_grid_pts <= 11'd1024;
            r_probe    <= '0;
            r_cell     <= '0;
            r_n        <= CNT_W'(2);
            r_k        <= '0;
            r_pass     <= '0;
            r_upc      <= '0;
            r_sat      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mbf_pkg::CFG_GRID_POINTS: r_grid_pts <= i_cfg_data;
                    mbf_pkg::CFG_PROBE_INDEX: r_probe    <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            // raise the result on the probe load, drop it once taken
            if (r_state == S_PLD && (!r_ov || o_result.ready)) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_item.mode == mbf_pkg::MODE_INIT) begin
                        r_k     <= '0;
                        r_state <= S_ILOAD;
                    end else if (w_acc && i_item.mode == mbf_pkg::MODE_STEP) begin
                        r_sat   <= 1'b0;
                        r_n     <= w_n;
                        r_cell  <= '0;
                        r_state <= S_CRD;
                    end
                end
                S_ILOAD: begin
                    r_k <= r_k + 1'b1;
                    if (int'(r_k) == 2 * REGION_MAX) begin
                        r_cell  <= '0;
                        r_state <= S_IFILL;
                    end
                end
                S_IFILL: begin
                    r_cell <= r_cell + 1'b1;
                    if (r_cell == CNT_W'(GRID_MAX - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CRD: r_state <= S_HRD;
                S_HRD: begin
                    r_k     <= '0;
                    r_state <= S_CLD;
                end
                S_CLD: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_W'(8)) begin
                        r_upc   <= '0;
                        r_pass  <= '0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_sat <= r_sat | w_sat;
                    if (r_upc == mbf_pkg::PASS_LAST) begin
                        r_upc <= '0;
                        if (r_pass == PS_W'(PC_PASSES - 1)) begin
                            r_state <= S_CWR;
                        end else begin
                            r_pass <= r_pass + 1'b1;
                        end
                    end else begin
                        r_upc <= r_upc + 1'b1;
                    end
                end
                S_CWR: begin
                    if (r_cell == r_n - 1'b1) begin
                        r_cell  <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_cell  <= r_cell + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_ERD: r_state <= S_ELD;
                S_ELD: r_state <= S_ECH;
                S_ECH: begin
                    r_upc   <= mbf_pkg::H_FIRST;
                    r_state <= S_HCALC;
                end
                S_HCALC: begin
                    r_sat <= r_sat | w_sat;
                    if (r_upc == mbf_pkg::H_LAST) begin
                        r_state <= S_HWR;
                    end else begin
                        r_upc <= r_upc + 1'b1;
                    end
                end
                S_HWR: begin
                    if (r_cell == r_n - 1'b1) begin
                        r_state <= S_PRD;
                    end else begin
                        r_cell  <= r_cell + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                S_PRD: r_state <= S_PLD;
                S_PLD: begin
                    if (!r_ov || o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_src <= i_item.source_value;
        end
        // capture region bounds and upper inits for grid init
        if (r_state == S_ILOAD) begin
            for (int j = 0; j < REGION_MAX; j++) begin
                if (int'(r_k) == j + 1) begin
                    r_last[j] <= w_coef;
                end
                if (int'(r_k) == REGION_MAX + j + 1) begin
                    r_upinit[j] <= w_coef;
                end
            end
        end
        // load stored cell and seed the estimates
        if (r_state == S_HRD) begin
            r_wk.lo  <= w_rd.lo;
            r_wk.up  <= w_rd.up;
            r_wk.crs <= w_rd.cr;
            r_wk.cis <= w_rd.ci;
            r_wk.efs <= w_rd.ef;
            r_wk.hfs <= w_rd.hf;
            r_wk.le  <= w_rd.lo;
            r_wk.ue  <= w_rd.up;
            r_wk.cre <= w_rd.cr;
            r_wk.cie <= w_rd.ci;
            r_wk.ee  <= w_rd.ef;
            r_region <= w_rd.rg;
        end
        if (r_state == S_CLD) begin
            // right neighbour H, zero beyond the last cell
            if (r_k == '0) begin
                r_wk.hn <= (CNT_W'(r_cell + 1'b1) < r_n) ? w_rd.hf : 32'sd0;
            end
            for (int j = 0; j < 8; j++) begin
                if (int'(r_k) == j + 1) begin
                    r_cf[j] <= w_coef;
                end
            end
        end
        // write back micro-op results; cell zero takes the hard source
        if (r_state == S_CALC || r_state == S_HCALC) begin
            case (w_uop.dst)
                mbf_pkg::O_LE:  r_wk.le  <= w_y;
                mbf_pkg::O_UE:  r_wk.ue  <= w_y;
                mbf_pkg::O_CRE: r_wk.cre <= w_y;
                mbf_pkg::O_CIE: r_wk.cie <= w_y;
                mbf_pkg::O_EE:  r_wk.ee  <= (r_cell == '0) ? r_src : w_y;
                mbf_pkg::O_R11: r_wk.r11 <= w_y;
                mbf_pkg::O_R22: r_wk.r22 <= w_y;
                mbf_pkg::O_RR:  r_wk.rr  <= w_y;
                mbf_pkg::O_RI:  r_wk.ri  <= w_y;
                mbf_pkg::O_OM:  r_wk.om  <= w_y;
                mbf_pkg::O_T:   r_wk.t   <= w_y;
                mbf_pkg::O_TR:  r_wk.tr  <= w_y;
                mbf_pkg::O_DRV: r_wk.drv <= w_y;
                mbf_pkg::O_T0:  r_wk.t0  <= w_y;
                mbf_pkg::O_T1:  r_wk.t1  <= w_y;
                default: ;
            endcase
        end
        // left neighbour E starts at zero for the H sweep
        if (r_state == S_CWR && r_cell == r_n - 1'b1) begin
            r_wk.epv <= 32'sd0;
        end
        if (r_state == S_ELD) begin
            r_wk.efs <= w_rd.ef;
            r_wk.hfs <= w_rd.hf;
        end
        if (r_state == S_ECH) begin
            r_cf[mbf_pkg::C_CH] <= w_coef;
        end
        if (r_state == S_HWR) begin
            r_wk.epv <= r_wk.efs;
        end
        // hold probe values for the result item
        if (r_state == S_PLD && (!r_ov || o_result.ready)) begin
            r_o_e   <= w_rd.ef;
            r_o_h   <= w_rd.hf;
            r_o_lo  <= w_rd.lo;
            r_o_up  <= w_rd.up;
            r_o_cr  <= w_rd.cr;
            r_o_ci  <= w_rd.ci;
            r_o_sat <= r_sat;
        end
    end

    assign o_result.valid           = r_ov;
    assign o_result.probe_e         = r_o_e;
    assign o_result.probe_h         = r_o_h;
    assign o_result.probe_lower_pop = r_o_lo;
    assign o_result.probe_upper_pop = r_o_up;
    assign o_result.probe_coh_real  = r_o_cr;
    assign o_result.probe_coh_imag  = r_o_ci;
    assign o_result.saturated       = r_o_sat;

    // pass counter stays within the configured pass count
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pass < PS_W'(PC_PASSES - 1)) || (r_pass == PS_W'(PC_PASSES - 1)))
        else $error("pass counter out of range");

    // a result appears only after the probe read
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_PLD))
        else $error("result raised outside probe load");

    // cell sweep stays inside the grid in use
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC || r_state == S_HCALC) |-> (r_cell < r_n))
        else $error("cell index beyond grid");

    // no new item is taken while a cell update is computed
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> !i_item.ready)
        else $error("input ready during cell update");
endmodule

`default_nettype wire
